/* rtl/core/plsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsb_pkg
// Shared types and constants for the periodic slot load balancer.
// ----------------------------------------------------------------------------
package plsb_pkg;

    // Default configuration of the polling tree
    localparam int MAX_BRANCHES_DEF = 32;
    localparam int TREE_LEVELS_DEF  = 6;
    localparam int USAGE_BITS_DEF   = 8;

    // Fixed field widths of the transaction payloads
    localparam int LEVEL_W    = 3;
    localparam int INDEX_W    = 5;
    localparam int INTERVAL_W = 8;
    localparam int USAGE_W    = 8;

    // Request opcodes
    localparam logic MODE_SELECT  = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SAT  = 2'd1,
        STATUS_ZERO = 2'd2
    } plsb_status_t;

    typedef struct packed {
        logic                  mode;
        logic [INTERVAL_W-1:0] interval;
        logic [LEVEL_W-1:0]    release_level;
        logic [INDEX_W-1:0]    release_index;
    } plsb_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] chosen_level;
        logic [INDEX_W-1:0] chosen_index;
        logic [USAGE_W-1:0] new_usage;
        logic [1:0]         status;
    } plsb_rsp_t;

endpackage

/* rtl/core/plsb_usage_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsb_usage_mem
// Use-count store: one write port, one registered read port, per-entry valid
// bits so that an entry not yet written reads as zero.
// ----------------------------------------------------------------------------
module plsb_usage_mem #(
    parameter int ADDR_BITS = plsb_pkg::TREE_LEVELS_DEF,
    parameter int DATA_BITS = plsb_pkg::USAGE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [DATA_BITS-1:0] rd_word_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

/* rtl/core/plsb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsb_ctrl
// Sequencer plus shared subtract/compare unit: level scan for selects,
// index wrap for releases, then a single count update.
// ----------------------------------------------------------------------------
module plsb_ctrl #(
    parameter int MAX_BRANCHES = plsb_pkg::MAX_BRANCHES_DEF,
    parameter int TREE_LEVELS  = plsb_pkg::TREE_LEVELS_DEF,
    parameter int USAGE_BITS   = plsb_pkg::USAGE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  plsb_pkg::plsb_req_t    req,
    input  logic                   hold,
    output logic                   idle,
    output logic                   done,
    output plsb_pkg::plsb_rsp_t    result,
    output logic [TREE_LEVELS-1:0] rd_addr,
    input  logic [USAGE_BITS-1:0]  rd_data,
    output logic                   wr_en,
    output logic [TREE_LEVELS-1:0] wr_addr,
    output logic [USAGE_BITS-1:0]  wr_data
);

    localparam int IW = $clog2(MAX_BRANCHES);
    localparam int CW = IW + 1;
    localparam int RW = (CW > plsb_pkg::INDEX_W) ? CW : plsb_pkg::INDEX_W;
    localparam int AW = TREE_LEVELS;
    localparam int UW = USAGE_BITS;
    localparam int DW = (UW > RW) ? UW : RW;
    localparam int LW = plsb_pkg::LEVEL_W;
    localparam logic [UW-1:0] UMAX = '1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRAP  = 5'b00100,
        S_RWAIT = 5'b01000,
        S_UPD   = 5'b10000
    } plsb_state_t;

    plsb_state_t state_reg, state_next;
    logic          mode_reg, mode_next;
    logic [LW-1:0] level_reg, level_next;
    logic [CW-1:0] n_reg, n_next;
    logic [AW-1:0] base_reg, base_next;
    logic [RW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cmp_reg, cmp_next;
    logic [IW-1:0] best_reg, best_next;
    logic [UW-1:0] val_reg, val_next;

    logic [LW-1:0] lvl_sel;
    logic [LW-1:0] lvl_in;
    logic [31:0]   pow_in;
    logic [31:0]   base_full;
    logic [CW-1:0] n_in;
    logic [AW-1:0] base_in;
    logic [31:0]   cur_full;
    logic [31:0]   wr_full;
    logic [DW-1:0] alu_a, alu_b;
    logic [DW:0]   alu_diff;
    logic          alu_lt;
    logic [UW-1:0] upd_val;
    logic          upd_write;
    plsb_pkg::plsb_status_t upd_status;
    logic [31:0]   best_full;
    logic [31:0]   use_full;

    // interval -> level: last power of two not above the interval
    always_comb
    begin
        lvl_sel = '0;
        for (int k = 0; k < TREE_LEVELS - 1; k++)
        begin
            if (32'(req.interval) >= (32'd2 << k))
            begin
                lvl_sel = LW'(k + 1);
            end
        end
    end

    always_comb
    begin
        if (req.mode == plsb_pkg::MODE_SELECT)
        begin
            lvl_in = lvl_sel;
        end
        else if (req.release_level >= LW'(TREE_LEVELS))
        begin
            lvl_in = LW'(TREE_LEVELS - 1);
        end
        else
        begin
            lvl_in = req.release_level;
        end
        pow_in    = 32'd1 << lvl_in;
        base_full = pow_in - 32'd1;
        base_in   = base_full[AW-1:0];
        n_in      = (pow_in > 32'(MAX_BRANCHES)) ? CW'(MAX_BRANCHES) : pow_in[CW-1:0];
    end

    // shared subtract/compare unit
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            alu_a = DW'(rd_data);
            alu_b = DW'(val_reg);
        end
        else
        begin
            alu_a = DW'(idx_reg);
            alu_b = DW'(n_reg);
        end
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_lt   = alu_diff[DW];
    end

    assign cur_full = 32'(base_reg) + 32'(idx_reg);
    assign wr_full  = 32'(base_reg) + 32'(best_reg);
    assign rd_addr  = (state_reg == S_IDLE) ? base_in : cur_full[AW-1:0];

    // count update: saturate at max on select, at zero on release
    always_comb
    begin
        upd_val    = val_reg;
        upd_write  = 1'b0;
        upd_status = plsb_pkg::STATUS_OK;
        if (mode_reg == plsb_pkg::MODE_SELECT)
        begin
            if (val_reg == UMAX)
            begin
                upd_status = plsb_pkg::STATUS_SAT;
            end
            else
            begin
                upd_val   = val_reg + UW'(1);
                upd_write = 1'b1;
            end
        end
        else
        begin
            if (val_reg == '0)
            begin
                upd_status = plsb_pkg::STATUS_ZERO;
            end
            else
            begin
                upd_val   = val_reg - UW'(1);
                upd_write = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        level_next = level_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        cmp_next   = cmp_reg;
        best_next  = best_reg;
        val_next   = val_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = req.mode;
                    level_next = lvl_in;
                    n_next     = n_in;
                    base_next  = base_in;
                    cmp_next   = '0;
                    if (req.mode == plsb_pkg::MODE_SELECT)
                    begin
                        idx_next   = RW'(1);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        idx_next   = RW'(req.release_index);
                        state_next = S_WRAP;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmp_reg == '0 || alu_lt)
                begin
                    val_next  = rd_data;
                    best_next = cmp_reg[IW-1:0];
                end
                idx_next = idx_reg + RW'(1);
                cmp_next = cmp_reg + CW'(1);
                if (cmp_reg == n_reg - CW'(1))
                begin
                    state_next = S_UPD;
                end
            end
            S_WRAP:
            begin
                if (alu_lt)
                begin
                    best_next  = idx_reg[IW-1:0];
                    state_next = S_RWAIT;
                end
                else
                begin
                    idx_next = alu_diff[RW-1:0];
                end
            end
            S_RWAIT:
            begin
                val_next   = rd_data;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!hold)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        level_reg <= level_next;
        n_reg     <= n_next;
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        cmp_reg   <= cmp_next;
        best_reg  <= best_next;
        val_reg   <= val_next;
    end

    assign idle    = (state_reg == S_IDLE);
    assign wr_en   = done && upd_write;
    assign wr_addr = wr_full[AW-1:0];
    assign wr_data = upd_val;

    assign best_full = 32'(best_reg);
    assign use_full  = 32'(upd_val);

    always_comb
    begin
        result.chosen_level = level_reg;
        result.chosen_index = best_full[plsb_pkg::INDEX_W-1:0];
        result.new_usage    = use_full[plsb_pkg::USAGE_W-1:0];
        result.status       = upd_status;
    end

endmodule

/* rtl/core/periodic_slot_load_balancer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_slot_load_balancer
// Least-used branch selection and release over a periodic polling tree.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload           | direction
//  --------+----------------------+-------------------+----------
//  req     | req_valid/req_ready  | plsb_req_t        | in
//  rsp     | rsp_valid/rsp_ready  | plsb_rsp_t        | out
//
//  Select transaction: the n counts of the level are scanned, n being the
//  branch count of the level (32 for the widest level at defaults); one
//  count is read per cycle through the store's single read port.
//  Release transaction: an out-of-range index is wrapped by repeated
//  subtraction of n in the shared subtract unit (at most 31 / n times).
//  Reset clears the state machine, the response valid and all count valid
//  bits at once; no clearing sweep is needed.
//  A stalled response is held in the output register; the update step waits
//  only when that register is still full and not being drained.
// ----------------------------------------------------------------------------
module periodic_slot_load_balancer #(
    parameter int MAX_BRANCHES = plsb_pkg::MAX_BRANCHES_DEF,
    parameter int TREE_LEVELS  = plsb_pkg::TREE_LEVELS_DEF,
    parameter int USAGE_BITS   = plsb_pkg::USAGE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  plsb_pkg::plsb_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output plsb_pkg::plsb_rsp_t rsp
);

    // Counters are laid out level by level: level k starts at 2^k - 1.
    logic                   start;
    logic                   hold;
    logic                   idle;
    logic                   done;
    plsb_pkg::plsb_rsp_t    result;
    logic [TREE_LEVELS-1:0] rd_addr;
    logic [USAGE_BITS-1:0]  rd_data;
    logic                   wr_en;
    logic [TREE_LEVELS-1:0] wr_addr;
    logic [USAGE_BITS-1:0]  wr_data;

    logic                   rsp_valid_reg, rsp_valid_next;
    plsb_pkg::plsb_rsp_t    rsp_reg;

    // one transaction at a time: take a new one only when the sequencer is idle
    assign req_ready = idle;
    assign start     = req_valid && idle;

    // output register full and not draining this cycle
    assign hold = rsp_valid_reg && !rsp_ready;

    plsb_ctrl #(
        .MAX_BRANCHES (MAX_BRANCHES),
        .TREE_LEVELS  (TREE_LEVELS),
        .USAGE_BITS   (USAGE_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .hold    (hold),
        .idle    (idle),
        .done    (done),
        .result  (result),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    plsb_usage_mem #(
        .ADDR_BITS (TREE_LEVELS),
        .DATA_BITS (USAGE_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/plsb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsb_checker
// Port-level assertions for the load balancer, bound to the top level.
// ----------------------------------------------------------------------------
module plsb_checker #(
    parameter int TREE_LEVELS = plsb_pkg::TREE_LEVELS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input plsb_pkg::plsb_rsp_t rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // only the three defined status codes
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == plsb_pkg::STATUS_OK ||
                       rsp.status == plsb_pkg::STATUS_SAT ||
                       rsp.status == plsb_pkg::STATUS_ZERO))
        else $error("illegal status code");

    // an ignored release reports a zero count
    a_zero_usage: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == plsb_pkg::STATUS_ZERO |-> rsp.new_usage == '0)
        else $error("zero-release status with nonzero count");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.chosen_level) < 32'(TREE_LEVELS))
        else $error("reported level out of range");

    // block is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after accept");

endmodule

bind periodic_slot_load_balancer plsb_checker #(
    .TREE_LEVELS (TREE_LEVELS)
) u_plsb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
